FILE: hw/rtl/madn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// madn_pkg - shared definitions for the MAC address normaliser
// Character codes, status codes, register indexes, result type and helpers.
// ----------------------------------------------------------------------------
package madn_pkg;

    localparam int MaxResults = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_OCTET_COUNT    = 2'd0;
    localparam logic [1:0] CFG_OUT_SEPARATOR  = 2'd1;
    localparam logic [1:0] CFG_UPPER_CASE     = 2'd2;
    localparam logic [1:0] CFG_ALLOW_TRAILING = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_BAD_FIRST  = 3'd2;
    localparam logic [2:0] ST_NO_HEX     = 3'd3;
    localparam logic [2:0] ST_WRONG_SEP  = 3'd4;
    localparam logic [2:0] ST_SEP_AT_END = 3'd5;
    localparam logic [2:0] ST_TRAILING   = 3'd6;

    // separator modes
    localparam logic [1:0] SEP_UNLEARNED = 2'd0;
    localparam logic [1:0] SEP_CHAR      = 2'd1;
    localparam logic [1:0] SEP_NONE      = 2'd2;

    // characters
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    localparam logic [6:0] OCTET_COUNT_RST = 7'd6;
    localparam logic [9:0] POS_MAX         = 10'd1023;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic [2:0] status;
        logic [9:0] error_offset;
    } t_res;

    // {valid, nibble}
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                     (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [7:0] f_digit(input logic [3:0] v, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (v < 4'd10) begin
            return CH_ZERO + {4'h0, v};
        end
        return base + {4'h0, v} - 8'd10;
    endfunction

    function automatic t_res f_res(input logic [7:0] ch, input logic last,
                                   input logic [2:0] st, input logic [9:0] off);
        t_res r;
        r.out_char     = ch;
        r.out_last     = last;
        r.status       = st;
        r.error_offset = off;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mac_address_normalizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mac_address_normalizer_unit - MAC address string normaliser
// Parses one character per transfer, learns the separator, emits each octet
// as two hex characters with the chosen separator and ends with a newline or
// one coded error item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  in       sink       i_in_valid / o_in_stall      i_char_in, i_is_end
//  out      source     o_out_valid / i_out_stall    o_out_char, o_out_last,
//                                                   o_status, o_error_offset
//  cfg      sink       i_cfg_we                     i_cfg_index, i_cfg_data
//
//  A character is decoded in the cycle it is transferred; its results (0 to 4)
//  land in a four-entry result buffer that drains one per cycle unless stalled.
//  A character with more than one result stalls the input while the result
//  buffer drains.
//  The input is taken again in the cycle the last buffered result transfers.
//  Reset (synchronous, active low) restores the register defaults and the
//  parser state and empties the result buffer.
//  Output stall only backs up the buffer; no result is lost or repeated.
// ----------------------------------------------------------------------------
module mac_address_normalizer_unit
    import madn_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_is_end,
    // output channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_out_last,
    output logic [2:0]      o_status,
    output logic [9:0]      o_error_offset,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    // configuration registers
    logic [6:0] r_octet_count;
    logic [7:0] r_out_sep;
    logic       r_upper;
    logic       r_allow_trail;

    // parser state and its next value
    logic       r_phase,    n_phase;
    logic [1:0] r_digits,   n_digits;
    logic [3:0] r_held,     n_held;
    logic [6:0] r_octet,    n_octet;
    logic [1:0] r_mode,     n_mode;
    logic [7:0] r_lsep,     n_lsep;
    logic [9:0] r_pos,      n_pos;
    logic       r_complete, n_complete;
    logic       r_err,      n_err;

    // result buffer: entry 0 is presented on the output
    t_res       r_res [MaxResults];
    t_res       n_res [MaxResults];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    logic       w_in_xfer;
    logic       w_out_xfer;
    logic [4:0] w_hex;
    logic       w_is_hex;
    logic       w_do_gap;
    logic       w_do_take;

    assign o_out_valid    = (r_cnt != 3'd0);
    assign w_out_xfer     = o_out_valid && !i_out_stall;
    // take a new character once the buffer is empty or about to be
    assign o_in_stall     = !((r_cnt == 3'd0) || ((r_cnt == 3'd1) && !i_out_stall));
    assign w_in_xfer      = i_in_valid && !o_in_stall;

    assign o_out_char     = r_res[0].out_char;
    assign o_out_last     = r_res[0].out_last;
    assign o_status       = r_res[0].status;
    assign o_error_offset = r_res[0].error_offset;

    assign w_hex    = f_hex(i_char_in);
    assign w_is_hex = w_hex[4] && !i_is_end;

    // ------------------------------------------------------------------
    // Single-pass decode of one character. Results are appended in order
    // to n_res; n_cnt counts them. State updates follow the parse order,
    // so later steps see what earlier steps of the same character left.
    // ------------------------------------------------------------------
    always_comb begin
        n_phase    = r_phase;
        n_digits   = r_digits;
        n_held     = r_held;
        n_octet    = r_octet;
        n_mode     = r_mode;
        n_lsep     = r_lsep;
        n_pos      = r_pos;
        n_complete = r_complete;
        n_err      = r_err;
        n_cnt      = 3'd0;
        w_do_gap   = 1'b0;
        w_do_take  = 1'b0;
        for (int i = 0; i < MaxResults; i++) begin
            n_res[i] = f_res(8'h00, 1'b0, ST_OK, 10'd0);
        end

        // number phase: start or finish an octet
        if (!r_err) begin
            if (r_phase) begin
                if (r_digits == 2'd0) begin
                    w_do_take = 1'b1;
                end else begin
                    // emit the octet: two digits, or a padded single digit
                    n_res[0] = f_res(f_digit(w_is_hex ? r_held : 4'h0, r_upper),
                                     1'b0, ST_OK, 10'd0);
                    n_res[1] = f_res(f_digit(w_is_hex ? w_hex[3:0] : r_held, r_upper),
                                     1'b0, ST_OK, 10'd0);
                    n_cnt    = 3'd2;
                    n_phase  = 1'b0;
                    n_digits = 2'd0;
                    n_held   = 4'h0;
                    if (r_octet >= r_octet_count) begin
                        n_complete = 1'b1;
                    end
                    // a non-hex character after a lone digit opens the gap
                    w_do_gap = !w_is_hex;
                end
            end else begin
                w_do_gap = 1'b1;
            end
        end

        // separator gap
        if (w_do_gap) begin
            priority if (n_complete) begin
                if (i_is_end) begin
                    n_res[n_cnt[1:0]] = f_res(CH_NEWLINE, 1'b1, ST_OK, 10'd0);
                    n_cnt = n_cnt + 3'd1;
                end else if (!r_allow_trail) begin
                    n_err = 1'b1;
                    n_res[n_cnt[1:0]] = f_res(8'h00, 1'b1, ST_TRAILING, r_pos);
                    n_cnt = n_cnt + 3'd1;
                end
            end else if (n_mode == SEP_CHAR) begin
                if (!i_is_end && i_char_in == n_lsep) begin
                    if (r_out_sep != 8'h00) begin
                        n_res[n_cnt[1:0]] = f_res(r_out_sep, 1'b0, ST_OK, 10'd0);
                        n_cnt = n_cnt + 3'd1;
                    end
                    n_octet  = n_octet + 7'd1;
                    n_phase  = 1'b1;
                    n_digits = 2'd0;
                end else begin
                    n_err = 1'b1;
                    n_res[n_cnt[1:0]] = f_res(8'h00, 1'b1, ST_WRONG_SEP, r_pos);
                    n_cnt = n_cnt + 3'd1;
                end
            end else if (n_mode == SEP_UNLEARNED && i_is_end) begin
                n_err = 1'b1;
                n_res[n_cnt[1:0]] = f_res(8'h00, 1'b1, ST_SEP_AT_END, r_pos);
                n_cnt = n_cnt + 3'd1;
            end else begin
                // learn a character separator, or fall into no-separator mode
                if (n_mode == SEP_UNLEARNED) begin
                    if (!w_hex[4]) begin
                        n_lsep = i_char_in;
                        n_mode = SEP_CHAR;
                    end else begin
                        n_mode = SEP_NONE;
                    end
                end
                if (r_out_sep != 8'h00) begin
                    n_res[n_cnt[1:0]] = f_res(r_out_sep, 1'b0, ST_OK, 10'd0);
                    n_cnt = n_cnt + 3'd1;
                end
                n_octet  = n_octet + 7'd1;
                n_phase  = 1'b1;
                n_digits = 2'd0;
                // without a separator this character starts the next octet
                w_do_take = (n_mode != SEP_CHAR);
            end
        end

        // first digit of an octet
        if (w_do_take) begin
            if (!w_is_hex) begin
                n_err = 1'b1;
                n_res[n_cnt[1:0]] = f_res(8'h00, 1'b1,
                    (r_pos == 10'd0) ? (i_is_end ? ST_EMPTY : ST_BAD_FIRST) : ST_NO_HEX,
                    r_pos);
                n_cnt = n_cnt + 3'd1;
            end else begin
                n_held   = w_hex[3:0];
                n_digits = 2'd1;
            end
        end

        // end marker restarts the parser; otherwise advance the position
        if (i_is_end) begin
            n_phase    = 1'b1;
            n_digits   = 2'd0;
            n_held     = 4'h0;
            n_octet    = 7'd1;
            n_mode     = SEP_UNLEARNED;
            n_lsep     = 8'h00;
            n_pos      = 10'd0;
            n_complete = 1'b0;
            n_err      = 1'b0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 10'd1;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octet_count <= OCTET_COUNT_RST;
            r_out_sep     <= CH_COLON;
            r_upper       <= 1'b0;
            r_allow_trail <= 1'b0;
            r_phase       <= 1'b1;
            r_digits      <= 2'd0;
            r_held        <= 4'h0;
            r_octet       <= 7'd1;
            r_mode        <= SEP_UNLEARNED;
            r_lsep        <= 8'h00;
            r_pos         <= 10'd0;
            r_complete    <= 1'b0;
            r_err         <= 1'b0;
            r_cnt         <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OCTET_COUNT:    r_octet_count <= i_cfg_data[6:0];
                    CFG_OUT_SEPARATOR:  r_out_sep     <= i_cfg_data;
                    CFG_UPPER_CASE:     r_upper       <= i_cfg_data[0];
                    CFG_ALLOW_TRAILING: r_allow_trail <= i_cfg_data[0];
                endcase
            end
            if (w_in_xfer) begin
                r_phase    <= n_phase;
                r_digits   <= n_digits;
                r_held     <= n_held;
                r_octet    <= n_octet;
                r_mode     <= n_mode;
                r_lsep     <= n_lsep;
                r_pos      <= n_pos;
                r_complete <= n_complete;
                r_err      <= n_err;
                r_cnt      <= n_cnt;
            end else if (w_out_xfer) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    // result buffer payload: load on input transfer, shift on output transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_res <= n_res;
        end else if (w_out_xfer) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                r_res[i] <= r_res[i + 1];
            end
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result buffer count out of range");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_out_last && (o_out_char == 8'h00))
        else $error("error item must end the address and carry no character");

    a_drop_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && r_err |=> (r_cnt == 3'd0))
        else $error("character after an error produced a result");

    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && i_is_end |=> (r_pos == 10'd0) && !r_err && r_phase)
        else $error("end marker did not restart the parser");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |-> (r_cnt == 3'd0) || w_out_xfer)
        else $error("buffer overwritten with results pending");
`endif

endmodule
`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for mac_address_normalizer_unit
// Streams address strings character by character through the valid/stall
// handshake, predicts every normalised output character, separator, newline
// and error item in a behavioural model of the parser, and compares each
// output transfer field by field. A short table of directed characters comes
// first, then random well-formed, broken and noisy strings over several
// register settings, with random idling on both channels in most of them.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import madn_pkg::*;

    localparam int SettleCycles = 8;     // latency pause before writes and at the end
    localparam int QuietLimit   = 4000;  // cycles with no transfer before giving up

    // how a directed character is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,  // results come from the parser model
        ROW_ONE,      // exactly one error item, typed in the table
        ROW_NONE      // no result at all
    } t_row_kind;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        t_row_kind  kind;
        logic [2:0] st;
        logic [9:0] off;
    } t_dir_row;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_char_in      = 8'h00;
    logic       i_is_end       = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall    = 1'b0;
    logic [7:0] o_out_char;
    logic       o_out_last;
    logic [2:0] o_status;
    logic [9:0] o_error_offset;
    logic       i_cfg_we       = 1'b0;
    logic [1:0] i_cfg_index    = CFG_OCTET_COUNT;
    logic [7:0] i_cfg_data     = 8'h00;

    // side information that travels with a directed character
    t_row_kind  row_kind = ROW_PREDICT;
    logic [2:0] row_st   = ST_OK;
    logic [9:0] row_off  = 10'd0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    mac_address_normalizer_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_in      (i_char_in),
        .i_is_end       (i_is_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_char     (o_out_char),
        .o_out_last     (o_out_last),
        .o_status       (o_status),
        .o_error_offset (o_error_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Parser model: register copies, per-address state, expected output queue
    // ------------------------------------------------------------------------
    logic [6:0] cfg_octets;
    logic [7:0] cfg_sep;
    logic       cfg_upper;
    logic       cfg_trailing;

    logic       num_phase;    // waiting for hex digits rather than a gap
    logic [1:0] nib_count;    // digits held for the current octet
    logic [3:0] held_nib;
    logic [6:0] octet_idx;    // 1-based number of the octet being parsed
    logic [1:0] sep_mode;
    logic [7:0] sep_char;
    logic [9:0] char_pos;
    logic       addr_done;    // every octet seen, only the end may follow
    logic       in_error;     // drop everything up to the end marker

    t_res normalized_q[$];

    int mismatches      = 0;
    int chars_seen      = 0;
    int strings_seen    = 0;
    int outputs_checked = 0;
    int settings_used   = 1;
    int quiet_cycles    = 0;

    function automatic bit is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] folded;
        if (c <= CH_NINE) begin
            return 4'(c - CH_ZERO);
        end
        // fold to lower case, then count up from 'a'
        folded = c | 8'h20;
        return 4'(folded - CH_LOWER_A + 8'd10);
    endfunction

    function automatic logic [7:0] nib_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + 8'(v);
        end
        return (cfg_upper ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
    endfunction

    function automatic void emit(input logic [7:0] ch, input logic last,
                                 input logic [2:0] st, input logic [9:0] off);
        t_res r;
        r.out_char     = ch;
        r.out_last     = last;
        r.status       = st;
        r.error_offset = off;
        normalized_q.push_back(r);
    endfunction

    function automatic void clear_address();
        num_phase = 1'b1;
        nib_count = 2'd0;
        held_nib  = 4'd0;
        octet_idx = 7'd1;
        sep_mode  = SEP_UNLEARNED;
        sep_char  = 8'h00;
        char_pos  = 10'd0;
        addr_done = 1'b0;
        in_error  = 1'b0;
    endfunction

    function automatic void restore_defaults();
        cfg_octets   = OCTET_COUNT_RST;
        cfg_sep      = CH_COLON;
        cfg_upper    = 1'b0;
        cfg_trailing = 1'b0;
        clear_address();
    endfunction

    function automatic void load_register(input logic [1:0] idx, input logic [7:0] val);
        case (idx)
            CFG_OCTET_COUNT:    cfg_octets   = val[6:0];
            CFG_OUT_SEPARATOR:  cfg_sep      = val;
            CFG_UPPER_CASE:     cfg_upper    = val[0];
            CFG_ALLOW_TRAILING: cfg_trailing = val[0];
            default: ;
        endcase
    endfunction

    function automatic void raise_error(input logic [2:0] st, input logic [9:0] pos);
        in_error = 1'b1;
        emit(8'h00, 1'b1, st, pos);
    endfunction

    // first digit of an octet, or the reason there is none
    function automatic void first_digit(input logic [7:0] c, input logic fin,
                                        input logic [9:0] pos);
        if (fin) begin
            raise_error((pos == 10'd0) ? ST_EMPTY : ST_NO_HEX, pos);
        end else if (!is_hex(c)) begin
            raise_error((pos == 10'd0) ? ST_BAD_FIRST : ST_NO_HEX, pos);
        end else begin
            held_nib  = hex_val(c);
            nib_count = 2'd1;
        end
    endfunction

    function automatic void close_octet(input logic [7:0] v);
        emit(nib_char(v[7:4]), 1'b0, ST_OK, 10'd0);
        emit(nib_char(v[3:0]), 1'b0, ST_OK, 10'd0);
        num_phase = 1'b0;
        nib_count = 2'd0;
        held_nib  = 4'd0;
        if (octet_idx >= cfg_octets) begin
            addr_done = 1'b1;
        end
    endfunction

    function automatic void open_octet();
        if (cfg_sep != 8'h00) begin
            emit(cfg_sep, 1'b0, ST_OK, 10'd0);
        end
        octet_idx = octet_idx + 7'd1;
        num_phase = 1'b1;
        nib_count = 2'd0;
    endfunction

    // a character that falls between two octets
    function automatic void gap_char(input logic [7:0] c, input logic fin,
                                     input logic [9:0] pos);
        if (addr_done) begin
            if (fin) begin
                emit(CH_NEWLINE, 1'b1, ST_OK, 10'd0);
            end else if (!cfg_trailing) begin
                raise_error(ST_TRAILING, pos);
            end
            return;
        end
        if (sep_mode == SEP_CHAR) begin
            if (!fin && c == sep_char) begin
                open_octet();
            end else begin
                raise_error(ST_WRONG_SEP, pos);
            end
            return;
        end
        if (sep_mode == SEP_UNLEARNED) begin
            if (fin) begin
                raise_error(ST_SEP_AT_END, pos);
                return;
            end
            if (!is_hex(c)) begin
                sep_char = c;
                sep_mode = SEP_CHAR;
                open_octet();
                return;
            end
            sep_mode = SEP_NONE;
        end
        // no separator: this character already starts the next octet
        open_octet();
        first_digit(c, fin, pos);
    endfunction

    function automatic void normalize_char(input logic [7:0] c, input logic fin);
        logic [9:0] pos;
        pos = char_pos;
        if (!in_error) begin
            if (!num_phase) begin
                gap_char(c, fin, pos);
            end else if (nib_count == 2'd0) begin
                first_digit(c, fin, pos);
            end else if (!fin && is_hex(c)) begin
                close_octet({held_nib, hex_val(c)});
            end else begin
                // a lone digit closes the octet; the character is then a gap
                close_octet({4'h0, held_nib});
                gap_char(c, fin, pos);
            end
        end
        if (fin) begin
            clear_address();
        end else if (char_pos != POS_MAX) begin
            char_pos = char_pos + 10'd1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    function automatic void report_field(input string field, input logic [9:0] want,
                                         input logic [9:0] got);
        mismatches++;
        $display("%0t ns: %s expected %h, actual %h", $time, field, want, got);
    endfunction

    function automatic void accept_char();
        int held;
        held = normalized_q.size();
        normalize_char(i_char_in, i_is_end);
        chars_seen++;
        if (i_is_end) begin
            strings_seen++;
        end
        // directed rows with a typed answer replace whatever the model produced
        if (row_kind != ROW_PREDICT) begin
            while (normalized_q.size() > held) begin
                void'(normalized_q.pop_back());
            end
            if (row_kind == ROW_ONE) begin
                emit(8'h00, 1'b1, row_st, row_off);
            end
        end
    endfunction

    function automatic void check_output();
        t_res want;
        if (normalized_q.size() == 0) begin
            mismatches++;
            $display("%0t ns: output expected none, actual char %h last %b status %0d",
                     $time, o_out_char, o_out_last, o_status);
            return;
        end
        want = normalized_q.pop_front();
        outputs_checked++;
        if (o_out_char !== want.out_char) begin
            report_field("out_char", 10'(want.out_char), 10'(o_out_char));
        end
        if (o_out_last !== want.out_last) begin
            report_field("out_last", 10'(want.out_last), 10'(o_out_last));
        end
        if (o_status !== want.status) begin
            report_field("status", 10'(want.status), 10'(o_status));
        end
        if (o_error_offset !== want.error_offset) begin
            report_field("error_offset", want.error_offset, o_error_offset);
        end
    endfunction

    // Sample every channel at the rising edge: register writes first, then the
    // accepted character, then the output transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            if (i_cfg_we) begin
                load_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                accept_char();
            end
            if (o_out_valid && !i_out_stall) begin
                check_output();
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Watchdog: give up when nothing has moved for too long.
    initial begin
        while (quiet_cycles < QuietLimit) begin
            @(posedge i_clk);
        end
        $display("timeout after %0d cycles without a transfer", QuietLimit);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    logic [8:0] addr_q[$];  // {end marker, character}

    // Offer one character; hold it until the transfer, idling first at random.
    task automatic send_char(input logic [7:0] c, input logic fin, input t_row_kind kind,
                             input logic [2:0] st, input logic [9:0] off);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        i_is_end   <= fin;
        row_kind   <= kind;
        row_st     <= st;
        row_off    <= off;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Drop valid and hold until every predicted result has transferred.
    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (normalized_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] octets, input logic [7:0] sep,
                                input logic [7:0] upper, input logic [7:0] trailing);
        write_reg(CFG_OCTET_COUNT, octets);
        write_reg(CFG_OUT_SEPARATOR, sep);
        write_reg(CFG_UPPER_CASE, upper);
        write_reg(CFG_ALLOW_TRAILING, trailing);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] rand_digit();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < 4'd10) begin
            return CH_ZERO + 8'(v);
        end
        return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
    endfunction

    // Build one string: mostly well-formed for the current octet count, the
    // rest mutated, truncated, padded with trailing bytes or pure noise.
    task automatic gen_address(input bit clean);
        int         n_oct;
        int         k;
        int         cut;
        bit         nosep;
        bit         one;
        logic [7:0] sep;
        addr_q.delete();
        n_oct = (cfg_octets == 7'd0) ? 1 : int'(cfg_octets);
        if (!clean && $urandom_range(99) < 15) begin
            n_oct = $urandom_range(1, n_oct + 2);
        end
        nosep = ($urandom_range(3) == 0);
        do begin
            sep = 8'($urandom_range(255));
        end while (is_hex(sep));
        for (int i = 0; i < n_oct; i++) begin
            if (i != 0 && !nosep) begin
                addr_q.push_back({1'b0, sep});
            end
            // without a separator only the last octet may be a lone digit
            one = nosep ? (i == n_oct - 1 && $urandom_range(3) == 0)
                        : ($urandom_range(2) == 0);
            if (!one) begin
                addr_q.push_back({1'b0, rand_digit()});
            end
            addr_q.push_back({1'b0, rand_digit()});
        end
        if (!clean) begin
            k = $urandom_range(99);
            if (k < 12) begin
                addr_q[$urandom_range(addr_q.size() - 1)] = {1'b0, 8'($urandom_range(255))};
            end else if (k < 22) begin
                cut = $urandom_range(addr_q.size() - 1);
                while (addr_q.size() > cut) begin
                    void'(addr_q.pop_back());
                end
            end else if (k < 30) begin
                addr_q.delete();
                repeat ($urandom_range(6)) addr_q.push_back({1'b0, 8'($urandom_range(255))});
            end else if (k < 45) begin
                repeat ($urandom_range(1, 3)) addr_q.push_back({1'b0, 8'($urandom_range(255))});
            end
        end
        // the character under an end marker is ignored; drive it random anyway
        addr_q.push_back({1'b1, 8'($urandom_range(255))});
    endtask

    task automatic send_address();
        foreach (addr_q[i]) begin
            send_char(addr_q[i][7:0], addr_q[i][8], ROW_PREDICT, ST_OK, 10'd0);
        end
    endtask

    // Program a setting once idle, then stream strings until the budget is used.
    task automatic run_phase(input logic [7:0] octets, input logic [7:0] sep,
                             input logic [7:0] upper, input logic [7:0] trailing,
                             input int src_pct, input int sink_pct,
                             input int budget, input bit clean);
        int start;
        wait_idle();
        program_regs(octets, sep, upper, trailing);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start = chars_seen;
        while (chars_seen - start < budget) begin
            gen_address(clean);
            send_address();
            // now and then hold the sender until the output side has caught up
            if ($urandom_range(5) == 0) begin
                wait_results();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed characters, run with the register values out of reset
    // ------------------------------------------------------------------------
    t_dir_row dir_rows [23] = '{
        // empty string; the character under the end marker is ignored
        '{"7",    1'b1, ROW_ONE,     ST_EMPTY,     10'd0},
        // bad first character, just below '0', then the dropped end
        '{"/",    1'b0, ROW_ONE,     ST_BAD_FIRST, 10'd0},
        '{8'hFF,  1'b1, ROW_NONE,    ST_OK,        10'd0},
        // top byte as first character, then a character dropped after the error
        '{8'hFF,  1'b0, ROW_ONE,     ST_BAD_FIRST, 10'd0},
        '{"x",    1'b0, ROW_NONE,    ST_OK,        10'd0},
        '{8'h00,  1'b1, ROW_NONE,    ST_OK,        10'd0},
        // lone digit closed by the separator, end where a digit should be
        '{"9",    1'b0, ROW_NONE,    ST_OK,        10'd0},
        '{":",    1'b0, ROW_PREDICT, ST_OK,        10'd0},
        '{8'h00,  1'b1, ROW_ONE,     ST_NO_HEX,    10'd2},
        // lone digit then end before any separator was learned
        '{"f",    1'b0, ROW_NONE,    ST_OK,        10'd0},
        '{"A",    1'b1, ROW_PREDICT, ST_OK,        10'd0},
        // NUL learned as separator, end in the gap after a lone digit
        '{"a",    1'b0, ROW_NONE,    ST_OK,        10'd0},
        '{"0",    1'b0, ROW_PREDICT, ST_OK,        10'd0},
        '{8'h00,  1'b0, ROW_PREDICT, ST_OK,        10'd0},
        '{"F",    1'b0, ROW_NONE,    ST_OK,        10'd0},
        '{8'h00,  1'b1, ROW_PREDICT, ST_OK,        10'd0},
        // no separator mode, end where the next octet should start
        '{"1",    1'b0, ROW_NONE,    ST_OK,        10'd0},
        '{"2",    1'b0, ROW_PREDICT, ST_OK,        10'd0},
        '{"B",    1'b0, ROW_PREDICT, ST_OK,        10'd0},
        '{"c",    1'b0, ROW_PREDICT, ST_OK,        10'd0},
        '{"D",    1'b0, ROW_PREDICT, ST_OK,        10'd0},
        '{"e",    1'b0, ROW_PREDICT, ST_OK,        10'd0},
        '{"5",    1'b1, ROW_PREDICT, ST_OK,        10'd0}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // hold reset once, at the start
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender seldom idles, receiver often stalls
        src_idle_pct   = 7;
        sink_stall_pct = 65;
        foreach (dir_rows[i]) begin
            send_char(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].kind,
                      dir_rows[i].st, dir_rows[i].off);
        end

        // reset values written back explicitly
        run_phase(8'd6, CH_COLON, 8'd0, 8'd1 - 8'd1, 7, 65, 25, 1'b0);
        // single octet, no output separator, upper case, trailing ignored
        run_phase(8'd1, 8'h00, 8'd1, 8'd1, 7, 65, 25, 1'b0);

        // roles swap: sender often idles, receiver seldom stalls
        // long address, one clean string
        run_phase(8'd16, 8'hFF, 8'd0, 8'd0, 65, 7, 1, 1'b1);
        // octet count zero behaves as one
        run_phase(8'd0, "-", 8'd1, 8'd0, 65, 7, 25, 1'b0);

        // no idling on either side, random separator, case and trailing setting
        run_phase(8'd3, 8'($urandom_range(255)), 8'($urandom_range(1)),
                  8'($urandom_range(1)), 0, 0, 40, 1'b0);

        wait_idle();
        $display("covered %0d characters in %0d strings under %0d register settings",
                 chars_seen, strings_seen, settings_used);
        $display("compared %0d output characters, %0d mismatches",
                 outputs_checked, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
